>>> rtl/core/rpn_pkg.sv
// rpn_pkg: shared types, codes and constants of the RPN stack evaluator.
// No dependencies; imported by rpn_iter, rpn_stack_evaluator_unit and the testbench.
package rpn_pkg;

    localparam int VAL_W           = 48;          // Q31.16 word
    localparam int PROD_W          = 2 * VAL_W;   // full product / wide quotient
    localparam int DEF_STACK_DEPTH = 128;
    localparam int DEF_FRAC_BITS   = 16;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REQ_PUSH    = 3'd0,
        REQ_ADD     = 3'd1,
        REQ_SUB     = 3'd2,
        REQ_MUL     = 3'd3,
        REQ_DIV     = 3'd4,
        REQ_MOD     = 3'd5,
        REQ_PRINT   = 3'd6,
        REQ_UNKNOWN = 3'd7
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_ZDIV    = 3'd3,
        ST_NONINT  = 3'd4,
        ST_UNKNOWN = 3'd5,
        ST_SAT     = 3'd6
    } t_status;

    typedef struct packed {
        t_req_type               req_type;
        logic signed [VAL_W-1:0] operand;
    } t_in_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] printed_value;
        logic                    printed_valid;
        t_status                 status;
        logic [7:0]              stack_depth;
    } t_out_res;

    // Operations of the shared iterative unit
    typedef enum logic [1:0] {
        ITER_MUL = 2'd0,
        ITER_DIV = 2'd1,
        ITER_MOD = 2'd2
    } t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_ctl;

endpackage

>>> rtl/core/rpn_ram.sv
// rpn_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/rpn_iter.sv
// rpn_iter: shared shift-add multiplier and restoring divider, one bit per cycle.
// Depends on rpn_pkg. One 50-bit adder serves all operations.
module rpn_iter
    import rpn_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_iter_ctl         i_ctl,
    input  logic [VAL_W-1:0]  i_ma,      // magnitude of left operand
    input  logic [VAL_W-1:0]  i_mb,      // magnitude of right operand
    output logic              o_busy,
    output logic [PROD_W-1:0] o_quot,    // mul: product >> FRAC_BITS, div: quotient
    output logic [VAL_W-1:0]  o_rem      // remainder (mod)
);

    localparam int NUMW = VAL_W + FRAC_BITS;
    localparam int CNTW = $clog2(NUMW + 1);

    logic             r_busy;
    t_iter_op         r_op;
    logic [CNTW-1:0]  r_cnt;
    logic [VAL_W-1:0] r_hi;
    logic [NUMW-1:0]  r_lo;
    logic [VAL_W-1:0] r_dvs;

    logic [VAL_W:0]    add_x;
    logic [VAL_W:0]    add_y;
    logic              add_sub;
    logic [VAL_W+1:0]  add_t;
    logic              ge;
    logic [PROD_W-1:0] prod;

    // shared adder
    always_comb begin
        if (r_op == ITER_MUL) begin
            add_x   = {1'b0, r_hi};
            add_y   = r_lo[FRAC_BITS] ? {1'b0, r_dvs} : '0;
            add_sub = 1'b0;
        end else begin
            add_x   = {r_hi, r_lo[NUMW-1]};
            add_y   = {1'b0, r_dvs};
            add_sub = 1'b1;
        end
        add_t = {1'b0, add_x} + (add_sub ? ~{1'b0, add_y} : {1'b0, add_y})
                + (VAL_W+2)'(add_sub);
        ge    = ~add_t[VAL_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= ITER_MUL;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_op   <= i_ctl.op;
            r_cnt  <= (i_ctl.op == ITER_MUL) ? CNTW'(VAL_W) : CNTW'(NUMW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_hi  <= '0;
            r_dvs <= i_mb;
            r_lo  <= (i_ctl.op == ITER_MOD) ? NUMW'(i_ma) : (NUMW'(i_ma) << FRAC_BITS);
        end else if (r_busy) begin
            if (r_op == ITER_MUL) begin
                r_hi <= add_t[VAL_W:1];
                r_lo <= {add_t[0], r_lo[NUMW-1:1]};
            end else begin
                r_hi <= ge ? add_t[VAL_W-1:0] : add_x[VAL_W-1:0];
                r_lo <= {r_lo[NUMW-2:0], ge};
            end
        end
    end

    assign prod   = {r_hi, r_lo[NUMW-1 -: VAL_W]};
    assign o_quot = (r_op == ITER_MUL) ? (prod >> FRAC_BITS) : PROD_W'(r_lo);
    assign o_rem  = r_hi;
    assign o_busy = r_busy;

endmodule

>>> rtl/core/rpn_stack_evaluator_unit.sv
// rpn_stack_evaluator_unit: top level of the RPN fixed-point stack calculator.
// Depends on rpn_pkg, rpn_ram (operand stack) and rpn_iter (mul/div/mod unit).
//
// Usage:
//   Input channel (i_valid / o_stall, payload i_req): one request per item,
//   push, add, subtract, multiply, divide, modulus, print or unknown. A request
//   is taken when i_valid is high and o_stall low. o_stall is high whenever a
//   request is in progress; only one request is worked on at a time.
//   Output channel (o_valid / i_stall, payload o_res): exactly one result per
//   request, taken when o_valid is high and i_stall low.
//   Steps from request taken to result loaded in the output register: push
//     goes to the push state, unknown to done, print pops one entry, add/sub
//     pop two, add and push; mul, div and mod pop two, run the iterative unit
//     and push. A zero divisor on div ends after one pop, a rejected mod after
//     two. The next request is taken only once the result has been loaded.
//   The iterative unit retires one product or quotient bit per cycle; that
//   loop sets the rate of mul, div and mod. Each pop goes through a pop state
//   and a get state because the stack RAM has a registered read port.
//   The output register holds one result: a new request is accepted while it
//   waits, and the finished result is held in the sequencer until the
//   receiver drains the register.
//   Reset (synchronous, active low) empties the stack and clears the output valid flag.
//   Stack contents need no clearing since only entries below the pointer are
//   ever read.
module rpn_stack_evaluator_unit
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_req  i_req,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_res o_res
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [VAL_W-1:0] FRAC_MASK = (VAL_W'(1) << FRAC_BITS) - VAL_W'(1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_POPB = 10'b00_0000_0010,
        S_GETB = 10'b00_0000_0100,
        S_POPA = 10'b00_0000_1000,
        S_GETA = 10'b00_0001_0000,
        S_EXEC = 10'b00_0010_0000,
        S_ITER = 10'b00_0100_0000,
        S_POST = 10'b00_1000_0000,
        S_PUSH = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    // sequencer and stack pointer
    t_state           r_state, n_state;
    logic [SPW-1:0]   r_sp, n_sp;
    t_status          r_status, n_status;
    logic             r_live, n_live;     // last pop hit a real entry
    t_req_type        r_req, n_req;
    logic [VAL_W-1:0] r_a, n_a;
    logic [VAL_W-1:0] r_b, n_b;
    logic [VAL_W-1:0] r_val, n_val;       // value to push

    // output register
    logic     r_out_valid, n_out_valid;
    t_out_res r_out, n_out;

    // stack RAM
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_rdata;

    // iterative unit
    t_iter_ctl         iter_ctl;
    logic              iter_busy;
    logic [PROD_W-1:0] iter_quot;
    logic [VAL_W-1:0]  iter_rem;

    // datapath helpers
    logic [VAL_W-1:0] pop_val;
    logic [VAL_W-1:0] mag_a;
    logic [VAL_W-1:0] mag_b;
    logic [VAL_W:0]   sum;
    logic             res_neg;
    logic [VAL_W-1:0] lim;
    logic             over;
    logic [VAL_W-1:0] sat_mag;

    rpn_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_val),
        .i_raddr (AW'(r_sp - SPW'(1))),
        .o_rdata (ram_rdata)
    );

    rpn_iter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (iter_ctl),
        .i_ma    (mag_a),
        .i_mb    (mag_b),
        .o_busy  (iter_busy),
        .o_quot  (iter_quot),
        .o_rem   (iter_rem)
    );

    assign pop_val   = r_live ? ram_rdata : '0;
    assign mag_a     = r_a[VAL_W-1] ? -r_a : r_a;
    assign mag_b     = r_b[VAL_W-1] ? -r_b : r_b;
    assign ram_waddr = AW'(r_sp);

    // add/sub in 49 bits, mul/div saturation against the signed limit
    assign sum     = (r_req == REQ_SUB) ? ({r_a[VAL_W-1], r_a} - {r_b[VAL_W-1], r_b})
                                        : ({r_a[VAL_W-1], r_a} + {r_b[VAL_W-1], r_b});
    assign res_neg = r_a[VAL_W-1] ^ r_b[VAL_W-1];
    assign lim     = res_neg ? VAL_MIN : VAL_MAX;
    assign over    = (|iter_quot[PROD_W-1:VAL_W]) || (iter_quot[VAL_W-1:0] > lim);
    assign sat_mag = over ? lim : iter_quot[VAL_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_status    = r_status;
        n_live      = r_live;
        n_req       = r_req;
        n_a         = r_a;
        n_b         = r_b;
        n_val       = r_val;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        iter_ctl    = '{start: 1'b0, op: ITER_MUL};

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req    = i_req.req_type;
                    n_val    = i_req.operand;
                    n_status = ST_OK;
                    case (i_req.req_type)
                        REQ_PUSH:    n_state = S_PUSH;
                        REQ_UNKNOWN: begin
                            n_status = ST_UNKNOWN;
                            n_state  = S_DONE;
                        end
                        default:     n_state = S_POPB;
                    endcase
                end
            end
            S_POPB, S_POPA: begin
                // RAM reads sp-1 every cycle; data shows up next cycle
                if (r_sp != '0) begin
                    n_sp   = r_sp - SPW'(1);
                    n_live = 1'b1;
                end else begin
                    n_live = 1'b0;
                    if (r_status == ST_OK) n_status = ST_EMPTY;
                end
                n_state = (r_state == S_POPB) ? S_GETB : S_GETA;
            end
            S_GETB: begin
                n_b = pop_val;
                case (r_req)
                    REQ_PRINT: n_state = S_DONE;
                    REQ_DIV: begin
                        if (pop_val == '0) begin
                            if (r_status == ST_OK) n_status = ST_ZDIV;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_POPA;
                        end
                    end
                    default:   n_state = S_POPA;
                endcase
            end
            S_GETA: begin
                n_a     = pop_val;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_req)
                    REQ_ADD, REQ_SUB: begin
                        if (sum[VAL_W] != sum[VAL_W-1]) begin
                            n_val = sum[VAL_W] ? VAL_MIN : VAL_MAX;
                            if (r_status == ST_OK) n_status = ST_SAT;
                        end else begin
                            n_val = sum[VAL_W-1:0];
                        end
                        n_state = S_PUSH;
                    end
                    REQ_MUL: begin
                        iter_ctl = '{start: 1'b1, op: ITER_MUL};
                        n_state  = S_ITER;
                    end
                    REQ_DIV: begin
                        iter_ctl = '{start: 1'b1, op: ITER_DIV};
                        n_state  = S_ITER;
                    end
                    REQ_MOD: begin
                        if (((r_a & FRAC_MASK) != '0) || ((r_b & FRAC_MASK) != '0)) begin
                            if (r_status == ST_OK) n_status = ST_NONINT;
                            n_state = S_DONE;
                        end else if (r_b == '0) begin
                            if (r_status == ST_OK) n_status = ST_ZDIV;
                            n_state = S_DONE;
                        end else begin
                            iter_ctl = '{start: 1'b1, op: ITER_MOD};
                            n_state  = S_ITER;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_ITER: begin
                if (!iter_busy) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (r_req == REQ_MOD) begin
                    // remainder takes the sign of the dividend
                    n_val = r_a[VAL_W-1] ? -iter_rem : iter_rem;
                end else begin
                    n_val = res_neg ? -sat_mag : sat_mag;
                    if (over && (r_status == ST_OK)) n_status = ST_SAT;
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (r_sp < SPW'(STACK_DEPTH)) begin
                    ram_we = 1'b1;
                    n_sp   = r_sp + SPW'(1);
                end else if (r_status == ST_OK) begin
                    n_status = ST_FULL;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid             = 1'b1;
                    n_out.printed_valid     = (r_req == REQ_PRINT);
                    n_out.printed_value     = (r_req == REQ_PRINT) ? r_b : '0;
                    n_out.status            = r_status;
                    n_out.stack_depth       = 8'(r_sp);
                    n_state                 = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_status    <= ST_OK;
            r_live      <= 1'b0;
            r_req       <= REQ_PUSH;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_status    <= n_status;
            r_live      <= n_live;
            r_req       <= n_req;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_val <= n_val;
        r_out <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

>>> tb/rpn_result_checker.sv
`timescale 1ns / 100ps
// rpn_result_checker: watches both channels of the RPN stack evaluator and checks each result.
// Keeps its own copy of the operand stack and predicts every result in order.
// Depends on rpn_pkg for the request/result structs and the status codes.
module rpn_result_checker
    import rpn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  logic     i_req_stall,
    input  t_in_req  i_req,
    input  logic     i_res_valid,
    input  logic     i_res_stall,
    input  t_out_res i_res,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_checked
);

    localparam int DEPTH = DEF_STACK_DEPTH;
    localparam int FRAC  = DEF_FRAC_BITS;
    localparam logic [VAL_W-1:0] FRAC_MASK = (48'd1 << FRAC) - 48'd1;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [127:0]            t_wide;

    t_val     stack_mem [DEPTH];
    int       stack_ptr;
    t_status  step_status;
    t_out_res expected_results [$];
    int       fail_total;
    int       checked_total;

    // Only the first problem of a request is reported.
    function automatic void note(t_status s);
        if (step_status == ST_OK)
            step_status = s;
    endfunction

    function automatic t_val pop_value();
        if (stack_ptr > 0) begin
            stack_ptr--;
            return stack_mem[stack_ptr];
        end
        note(ST_EMPTY);
        return '0;
    endfunction

    function automatic void push_value(t_val v);
        if (stack_ptr < DEPTH) begin
            stack_mem[stack_ptr] = v;
            stack_ptr++;
        end else begin
            note(ST_FULL);
        end
    endfunction

    function automatic logic [VAL_W-1:0] magnitude(t_val v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_val clamp_magnitude(bit neg, t_wide m);
        t_wide limit;
        limit = neg ? t_wide'(VAL_MIN) : t_wide'(VAL_MAX);
        if (m > limit) begin
            note(ST_SAT);
            m = limit;
        end
        return neg ? 48'd0 - m[VAL_W-1:0] : m[VAL_W-1:0];
    endfunction

    function automatic t_out_res evaluate_request(t_in_req r);
        t_val                  a;
        t_val                  b;
        t_out_res              res;
        logic signed [VAL_W:0] sum;
        logic [VAL_W:0]        sum_mag;
        longint                rem;
        res = '0;
        step_status = ST_OK;
        case (r.req_type)
            REQ_PUSH: push_value(r.operand);
            REQ_ADD, REQ_SUB: begin
                b = pop_value();
                a = pop_value();
                if (r.req_type == REQ_ADD)
                    sum = a + b;
                else
                    sum = a - b;
                sum_mag = (sum < 0) ? -sum : sum;
                push_value(clamp_magnitude(sum < 0, t_wide'(sum_mag)));
            end
            REQ_MUL: begin
                b = pop_value();
                a = pop_value();
                push_value(clamp_magnitude((a < 0) != (b < 0),
                    (t_wide'(magnitude(a)) * t_wide'(magnitude(b))) >> FRAC));
            end
            REQ_DIV: begin
                b = pop_value();
                if (b == 0) begin
                    note(ST_ZDIV);
                end else begin
                    a = pop_value();
                    push_value(clamp_magnitude((a < 0) != (b < 0),
                        (t_wide'(magnitude(a)) << FRAC) / t_wide'(magnitude(b))));
                end
            end
            REQ_MOD: begin
                b = pop_value();
                a = pop_value();
                if ((magnitude(a) & FRAC_MASK) != 0 || (magnitude(b) & FRAC_MASK) != 0) begin
                    note(ST_NONINT);
                end else if (b == 0) begin
                    note(ST_ZDIV);
                end else begin
                    rem = longint'(a) % longint'(b);   // truncates toward zero
                    push_value(t_val'(rem));
                end
            end
            REQ_PRINT: begin
                res.printed_value = pop_value();
                res.printed_valid = 1'b1;
            end
            default: note(ST_UNKNOWN);
        endcase
        res.status      = step_status;
        res.stack_depth = 8'(stack_ptr);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_res exp_res;
        if (!i_rst_n) begin
            stack_ptr = 0;
            expected_results.delete();
        end else begin
            // Results first: a result never belongs to a request taken at the same edge.
            if (i_res_valid && !i_res_stall) begin
                checked_total++;
                if (expected_results.size() == 0) begin
                    if (fail_total < 10)
                        $display("%0t: result with nothing expected: value=%h valid=%b status=%0d depth=%0d",
                                 $realtime, i_res.printed_value, i_res.printed_valid,
                                 i_res.status, i_res.stack_depth);
                    fail_total++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_res.printed_value !== exp_res.printed_value ||
                        i_res.printed_valid !== exp_res.printed_valid ||
                        i_res.status !== exp_res.status ||
                        i_res.stack_depth !== exp_res.stack_depth) begin
                        if (fail_total < 10)
                            $display("%0t: mismatch: exp value=%h valid=%b status=%0d depth=%0d, got value=%h valid=%b status=%0d depth=%0d",
                                     $realtime, exp_res.printed_value, exp_res.printed_valid,
                                     exp_res.status, exp_res.stack_depth, i_res.printed_value,
                                     i_res.printed_valid, i_res.status, i_res.stack_depth);
                        fail_total++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                expected_results.push_back(evaluate_request(i_req));
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
        o_checked    <= checked_total;
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for rpn_stack_evaluator_unit.
// Directed corner requests, then random expressions, stack fills and noise.
// Depends on rpn_pkg, the evaluator RTL and rpn_result_checker.
module tb;
    import rpn_pkg::*;

    typedef logic signed [VAL_W-1:0] t_val;

    localparam longint ONE         = 64'sd1 <<< DEF_FRAC_BITS;
    localparam int     RANDOM_GOAL = 980;     // directed part plus about 950 random requests

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_in_req  i_req;
    logic     o_valid;
    logic     i_stall;
    t_out_res o_res;

    int fail_count;
    int pending;
    int checked;
    int sent_by_kind [8];
    int sent_total;
    int fills;
    bit in_calm;
    bit out_calm;

    always #5 i_clk = ~i_clk;

    rpn_stack_evaluator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    rpn_result_checker u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req        (i_req),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    function automatic t_val random_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[VAL_W-1:0];
    endfunction

    // Operand mix: full-width noise, extremes, zero, small integers for modulus,
    // fractions, mid-size values that multiply without saturating, and large integers.
    function automatic t_val pick_operand();
        int k;
        t_val v;
        case ($urandom_range(0, 9))
            0, 1: v = random_word();
            2: v = VAL_MAX;
            3: v = VAL_MIN;
            4: v = '0;
            5, 6: begin
                k = $urandom_range(0, 40);
                k = k - 20;
                v = t_val'(longint'(k) * ONE);
            end
            7: begin
                k = $urandom_range(0, 2 ** 21);
                k = k - 2 ** 20;
                v = t_val'(longint'(k));
            end
            8: v = t_val'(longint'(int'($urandom)));
            default: v = t_val'(longint'(int'($urandom)) <<< DEF_FRAC_BITS);
        endcase
        return v;
    endfunction

    // One request; the sender first idles for a random gap unless in a calm stretch.
    // Returns at the edge that takes the request, valid still high.
    task automatic send_request(t_req_type kind, t_val value);
        int      gap;
        t_in_req r;
        gap        = in_calm ? 0 : $urandom_range(0, 4);
        r.req_type = kind;
        r.operand  = value;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        sent_by_kind[kind]++;
        sent_total++;
    endtask

    // Receiver: stalls for a random gap ahead of each result, with calm stretches.
    initial begin
        int hold;
        i_stall  = 1'b0;
        out_calm = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
            hold = out_calm ? 0 : $urandom_range(0, 4);
            repeat (hold) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int        pick;
        int        terms;
        t_req_type kind;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        in_calm = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Underflow on an empty stack: print, binary ops, divide and modulus.
        send_request(REQ_PRINT, random_word());
        send_request(REQ_ADD, random_word());
        send_request(REQ_PRINT, random_word());
        send_request(REQ_DIV, random_word());
        send_request(REQ_MOD, random_word());
        // Saturation of add, subtract and multiply.
        send_request(REQ_PUSH, VAL_MAX);
        send_request(REQ_PUSH, VAL_MAX);
        send_request(REQ_ADD, random_word());
        send_request(REQ_PUSH, VAL_MIN);
        send_request(REQ_SUB, random_word());
        send_request(REQ_PUSH, VAL_MAX);
        send_request(REQ_MUL, random_word());
        // Zero divisor pops only the divisor.
        send_request(REQ_PUSH, '0);
        send_request(REQ_DIV, random_word());
        // Modulus with a fractional operand, with a negative left side, by zero.
        send_request(REQ_PUSH, t_val'(3 * ONE + ONE / 2));
        send_request(REQ_MOD, random_word());
        send_request(REQ_PUSH, t_val'(-7 * ONE));
        send_request(REQ_PUSH, t_val'(2 * ONE));
        send_request(REQ_MOD, random_word());
        send_request(REQ_PUSH, '0);
        send_request(REQ_MOD, random_word());
        // Fractional quotient, then the most negative value divided by minus one.
        send_request(REQ_PUSH, t_val'(ONE));
        send_request(REQ_PUSH, t_val'(3 * ONE));
        send_request(REQ_DIV, random_word());
        send_request(REQ_PUSH, VAL_MIN);
        send_request(REQ_PUSH, t_val'(-ONE));
        send_request(REQ_DIV, random_word());
        send_request(REQ_UNKNOWN, random_word());
        send_request(REQ_PRINT, random_word());
        send_request(REQ_PRINT, random_word());

        // Random part: mostly well-formed expressions, some noise, and at
        // least one pass that fills the stack past full and drains it.
        while (sent_total < RANDOM_GOAL) begin
            pick    = $urandom_range(0, 99);
            in_calm = ($urandom_range(0, 4) == 0);
            if ((pick < 2 && fills < 2) || (fills == 0 && sent_total > 400)) begin
                fills++;
                repeat (DEF_STACK_DEPTH + 3) send_request(REQ_PUSH, pick_operand());
                repeat (DEF_STACK_DEPTH + 6) begin
                    if ($urandom_range(0, 3) == 0)
                        kind = t_req_type'($urandom_range(REQ_ADD, REQ_MOD));
                    else
                        kind = REQ_PRINT;
                    send_request(kind, random_word());
                end
            end else if (pick < 82) begin
                terms = $urandom_range(2, 6);
                repeat (terms) send_request(REQ_PUSH, pick_operand());
                repeat (terms - 1)
                    send_request(t_req_type'($urandom_range(REQ_ADD, REQ_MOD)), random_word());
                if ($urandom_range(0, 4) != 0)
                    send_request(REQ_PRINT, random_word());
            end else begin
                repeat ($urandom_range(1, 5))
                    send_request(t_req_type'($urandom_range(0, 7)), pick_operand());
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        // Let the checker count the last request, then drain.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d requests: push %0d, add %0d, sub %0d, mul %0d, div %0d, mod %0d, print %0d, unknown %0d",
                 sent_total, sent_by_kind[REQ_PUSH], sent_by_kind[REQ_ADD], sent_by_kind[REQ_SUB],
                 sent_by_kind[REQ_MUL], sent_by_kind[REQ_DIV], sent_by_kind[REQ_MOD],
                 sent_by_kind[REQ_PRINT], sent_by_kind[REQ_UNKNOWN]);
        $display("Checked %0d results over %0d full-stack passes; %0d failures, %0d still expected",
                 checked, fills, fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
